// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion with reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication form
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)
`endif

// ===== hw/rtl/ttb_pkg.sv =====
// shared constants and types for the tangent basis block
// no dependencies
`timescale 1ns / 1ps
package ttb_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // datapath commands from the controller
    typedef struct packed {
        logic load_v0;
        logic load_v1;
        logic load_v2;
        logic mul_start;
        logic div_start;
        logic res_load;
        logic res_clear;
        logic out_load;
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_zero;
        logic last_comp;
    } t_stat;
endpackage

// ===== hw/rtl/ttb_ctrl.sv =====
// controller state machine for the tangent basis block
// depends on ttb_pkg
`timescale 1ns / 1ps
module ttb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ttb_pkg::t_stat i_stat,
    output ttb_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_DZ   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_slot, n_slot;
    logic       r_ov, n_ov;
    logic       acc;

    assign o_in_ready  = (r_state == S_IN);
    assign o_out_valid = r_ov;
    assign acc         = i_in_valid && o_in_ready;

    // sequencing
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_ov    = r_ov;
        o_cmd   = '0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IN: begin
                if (acc) begin
                    if (r_slot == 2'd1) begin
                        o_cmd.load_v1 = 1'b1;
                        n_slot = 2'd2;
                    end else if (r_slot == 2'd2) begin
                        o_cmd.load_v2   = 1'b1;
                        o_cmd.mul_start = 1'b1;
                        o_cmd.res_clear = 1'b1;
                        n_slot  = 2'd0;
                        n_state = S_MUL;
                    end else begin
                        o_cmd.load_v0 = 1'b1;
                        n_slot = 2'd1;
                    end
                end
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    if (i_stat.det_zero) n_state = S_DZ;
                    else begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.last_comp) n_state = S_OUT;
                    else o_cmd.div_start = 1'b1;
                end
            end
            // move the result into the output register once it is free
            S_DZ, S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_slot  <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_ov    <= n_ov;
        end
    end
endmodule

// ===== hw/rtl/ttb_datapath.sv =====
// datapath: vertex hold, shared multiplier, serial divider, result registers
// depends on ttb_pkg
`timescale 1ns / 1ps
module ttb_datapath #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttb_pkg::t_cmd                 i_cmd,
    output ttb_pkg::t_stat                o_stat,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    output logic signed [COORD_WIDTH-1:0] o_tangent_x,
    output logic signed [COORD_WIDTH-1:0] o_tangent_y,
    output logic signed [COORD_WIDTH-1:0] o_tangent_z,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_x,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_y,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_z,
    output logic                          o_degenerate,
    output logic                          o_overflow
);
    localparam int DW  = COORD_WIDTH + 1;       // delta width
    localparam int PW  = 2 * DW;                // product width
    localparam int NW  = PW + 1;                // numerator / det width
    localparam int SW  = NW + FRAC_BITS;        // scaled numerator width
    localparam int QW  = SW;                    // quotient width
    localparam int CNT = 4;
    localparam int NPROD = 14;
    localparam logic [QW-1:0] LIM_P = QW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic [QW-1:0] LIM_N = QW'(64'd1 << (COORD_WIDTH - 1));
    localparam logic signed [COORD_WIDTH-1:0] SMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // held vertices
    logic signed [COORD_WIDTH-1:0] r_p0 [3];
    logic signed [COORD_WIDTH-1:0] r_p1 [3];
    logic signed [COORD_WIDTH-1:0] r_t0 [2];
    logic signed [COORD_WIDTH-1:0] r_t1 [2];
    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic signed [DW-1:0] r_du1, r_dv1, r_du2, r_dv2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v0) begin
            r_p0[0] <= i_pos_x; r_p0[1] <= i_pos_y; r_p0[2] <= i_pos_z;
            r_t0[0] <= i_tex_u; r_t0[1] <= i_tex_v;
        end
        if (i_cmd.load_v1) begin
            r_p1[0] <= i_pos_x; r_p1[1] <= i_pos_y; r_p1[2] <= i_pos_z;
            r_t1[0] <= i_tex_u; r_t1[1] <= i_tex_v;
        end
        // edge vectors and uv deltas on the third vertex
        if (i_cmd.load_v2) begin
            for (int k = 0; k < 3; k++) begin
                r_d1[k] <= DW'(r_p1[k]) - DW'(r_p0[k]);
            end
            r_d2[0] <= DW'(i_pos_x) - DW'(r_p0[0]);
            r_d2[1] <= DW'(i_pos_y) - DW'(r_p0[1]);
            r_d2[2] <= DW'(i_pos_z) - DW'(r_p0[2]);
            r_du1 <= DW'(r_t1[0]) - DW'(r_t0[0]);
            r_dv1 <= DW'(r_t1[1]) - DW'(r_t0[1]);
            r_du2 <= DW'(i_tex_u) - DW'(r_t0[0]);
            r_dv2 <= DW'(i_tex_v) - DW'(r_t0[1]);
        end
    end

    // shared multiplier: one product a cycle, pairs combined by subtraction
    logic        r_mbusy;
    logic [3:0]  r_mstep;
    logic        r_mvld;
    logic [3:0]  r_mtag;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] r_prod, r_first;
    logic signed [NW-1:0] r_num [7];  // det, tangent x..z, bitangent x..z
    logic        r_mdone;

    always_comb begin
        mul_a = r_du1; mul_b = r_dv2;
        case (r_mstep)
            4'd0:  begin mul_a = r_du1;   mul_b = r_dv2; end
            4'd1:  begin mul_a = r_dv1;   mul_b = r_du2; end
            4'd2:  begin mul_a = r_d1[0]; mul_b = r_dv2; end
            4'd3:  begin mul_a = r_d2[0]; mul_b = r_dv1; end
            4'd4:  begin mul_a = r_d1[1]; mul_b = r_dv2; end
            4'd5:  begin mul_a = r_d2[1]; mul_b = r_dv1; end
            4'd6:  begin mul_a = r_d1[2]; mul_b = r_dv2; end
            4'd7:  begin mul_a = r_d2[2]; mul_b = r_dv1; end
            4'd8:  begin mul_a = r_d2[0]; mul_b = r_du1; end
            4'd9:  begin mul_a = r_d1[0]; mul_b = r_du2; end
            4'd10: begin mul_a = r_d2[1]; mul_b = r_du1; end
            4'd11: begin mul_a = r_d1[1]; mul_b = r_du2; end
            4'd12: begin mul_a = r_d2[2]; mul_b = r_du1; end
            4'd13: begin mul_a = r_d1[2]; mul_b = r_du2; end
            default: begin mul_a = r_du1; mul_b = r_dv2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mvld  <= 1'b0;
            r_mdone <= 1'b0;
            r_mstep <= '0;
            r_mtag  <= '0;
        end else begin
            r_mdone <= 1'b0;
            r_mvld  <= r_mbusy;
            r_mtag  <= r_mstep;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mstep <= '0;
            end else if (r_mbusy) begin
                if (r_mstep == 4'(NPROD - 1)) r_mbusy <= 1'b0;
                else r_mstep <= r_mstep + 4'd1;
            end
            if (r_mvld && r_mtag == 4'(NPROD - 1)) r_mdone <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_mvld) begin
            if (!r_mtag[0]) r_first <= r_prod;
            else r_num[r_mtag[3:1]] <= NW'(r_first) - NW'(r_prod);
        end
    end

    // restoring divider over one component at a time
    localparam int CW = $clog2(SW + 1);
    logic [2:0]    r_comp;
    logic          r_dbusy, r_ddone;
    logic [CW-1:0] r_dcnt;
    logic [SW-1:0] r_dn;
    logic [NW-1:0] r_dd;
    logic [NW:0]   r_rem;
    logic [QW-1:0] r_q;
    logic          r_neg;
    logic signed [NW-1:0] det_v;
    logic [NW:0]   trial;

    function automatic logic [NW-1:0] num_abs(input logic signed [NW-1:0] v);
        num_abs = v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    function automatic logic num_sel_next_neg();
        num_sel_next_neg = r_num[r_comp + 3'd1][NW-1] ^ det_v[NW-1];
    endfunction

    assign det_v   = r_num[0];
    assign trial   = {r_rem[NW-1:0], r_dn[SW-1]} - {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_comp  <= 3'd0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.mul_start) r_comp <= 3'd0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_comp  <= r_comp + 3'd1;
                r_dcnt  <= CW'(SW);
                r_rem   <= '0;
                r_q     <= '0;
                r_neg   <= num_sel_next_neg();
                r_dn    <= {NW'(num_abs(r_num[r_comp + 3'd1])), FRAC_BITS'(0)};
                r_dd    <= NW'(num_abs(det_v));
            end else if (r_dbusy) begin
                r_dn <= r_dn << 1;
                if (!trial[NW]) begin
                    r_rem <= trial;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[NW-1:0], r_dn[SW-1]};
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - CW'(1);
                if (r_dcnt == CW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // saturate and store the finished component
    logic signed [COORD_WIDTH-1:0] r_res [6];
    logic signed [COORD_WIDTH-1:0] sat_v;
    logic                          sat_o;
    logic                          r_deg, r_ovf;

    always_comb begin
        sat_o = r_neg ? (r_q > LIM_N) : (r_q > LIM_P);
        if (sat_o) sat_v = r_neg ? SMIN : SMAX;
        else if (r_neg) sat_v = COORD_WIDTH'(-r_q);
        else sat_v = COORD_WIDTH'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clear) begin
            for (int k = 0; k < 6; k++) r_res[k] <= '0;
            r_ovf <= 1'b0;
        end
        if (r_mdone) r_deg <= (det_v == '0);
        if (i_cmd.res_load) begin
            r_res[r_comp - 3'd1] <= sat_v;
            r_ovf <= r_ovf | sat_o;
        end
    end

    // output item registers, loaded once the previous item has left
    logic signed [COORD_WIDTH-1:0] r_out [6];
    logic                          r_out_deg, r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int k = 0; k < 6; k++) r_out[k] <= r_res[k];
            r_out_deg <= r_deg;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_stat.mul_done  = r_mdone;
    assign o_stat.div_done  = r_ddone;
    assign o_stat.det_zero  = (det_v == '0);
    assign o_stat.last_comp = (r_comp == 3'd6);

    assign o_tangent_x   = r_out[0];
    assign o_tangent_y   = r_out[1];
    assign o_tangent_z   = r_out[2];
    assign o_bitangent_x = r_out[3];
    assign o_bitangent_y = r_out[4];
    assign o_bitangent_z = r_out[5];
    assign o_degenerate  = r_out_deg;
    assign o_overflow    = r_out_ovf;
endmodule

// ===== hw/rtl/triangle_tangent_basis_core.sv =====
// tangent basis core: three vertex items in, one result item per triangle
// the result comes from the shared multiplier, then the serial divider per component;
// a degenerate triangle skips the divider
// throughput: a vertex item a cycle while idle; input stalls from the third vertex
// until the result moves to the output register
// synchronous active-low reset clears the vertex slot and the output valid
`timescale 1ns / 1ps
module triangle_tangent_basis_core #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_tangent_x,
    output logic signed [COORD_WIDTH-1:0] o_tangent_y,
    output logic signed [COORD_WIDTH-1:0] o_tangent_z,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_x,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_y,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_z,
    output logic                          o_degenerate,
    output logic                          o_overflow
);
    ttb_pkg::t_cmd  cmd;
    ttb_pkg::t_stat stat;

    ttb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    ttb_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tex_u(i_tex_u), .i_tex_v(i_tex_v),
        .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y),
        .o_tangent_z(o_tangent_z), .o_bitangent_x(o_bitangent_x),
        .o_bitangent_y(o_bitangent_y), .o_bitangent_z(o_bitangent_z),
        .o_degenerate(o_degenerate), .o_overflow(o_overflow)
    );
endmodule

// ===== hw/rtl/ttb_checker.sv =====
// port-level checks on the tangent basis core, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_degenerate,
    input logic o_overflow
);
    logic       out_stall;
    logic       out_deg;
    logic [1:0] flags;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_deg   = o_out_valid && o_degenerate;
    assign flags     = {o_degenerate, o_overflow};

    // a held result item stays until taken
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, out_stall, ##1 o_out_valid, "result lost")
    // a held result item keeps its flags
    `ASSERT_IMPL(a_flag_hold, i_clk, i_rst_n, out_stall, ##1 $stable(flags), "flags moved")
    // degenerate results never flag overflow
    `ASSERT_IMPL(a_deg_ovf, i_clk, i_rst_n, out_deg, !o_overflow, "degenerate with overflow")
endmodule

bind triangle_tangent_basis_core ttb_checker u_ttb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_degenerate(o_degenerate),
    .o_overflow(o_overflow)
);
